FILE: hdl/lqs_pkg.sv
// ----------------------------------------------------------------------------
// lqs_pkg
// Types and constants shared by the link quality statistics block.
// ----------------------------------------------------------------------------
package lqs_pkg;

    localparam logic [1:0] FUNC_SENT  = 2'd0;
    localparam logic [1:0] FUNC_RECV  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam int RSSI_W     = 11;
    localparam int SNR_W      = 9;
    localparam int RTT_IN_W   = 24;
    localparam int LOSS_W     = 14;
    localparam int LOSS_SCALE = 10000;
    localparam int RSSI_FLOOR = -800;
    localparam int SNR_LIMIT  = 200;

    // division operand select
    typedef enum logic [1:0] {
        DIV_LOSS = 2'd0,
        DIV_RSSI = 2'd1,
        DIV_SNR  = 2'd2,
        DIV_RTT  = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     update;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_store;
    } t_lqs_cmd;

    typedef struct packed {
        logic div_done;
    } t_lqs_sts;

endpackage

FILE: hdl/lqs_ctrl.sv
// ----------------------------------------------------------------------------
// lqs_ctrl
// Sequencer: state update, then four divisions on the shared divider.
// ----------------------------------------------------------------------------
module lqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lqs_pkg::t_lqs_cmd o_cmd,
    input  lqs_pkg::t_lqs_sts i_sts
);
    import lqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_WAIT, S_OUT
    } t_state;

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;
    logic     r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.update = 1'b1;
                    n_sel   = DIV_LOSS;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == DIV_RTT) begin
                        n_out_valid = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_sel   = t_div_sel'(r_sel + 2'd1);
                        n_state = S_START;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= DIV_LOSS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: hdl/lqs_div.sv
// ----------------------------------------------------------------------------
// lqs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lqs_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;

    assign w_shift = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem  <= w_diff;
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;
endmodule

FILE: hdl/lqs_datapath.sv
// ----------------------------------------------------------------------------
// lqs_datapath
// Counters, sums, extremes and the shared divider with result registers.
// ----------------------------------------------------------------------------
module lqs_datapath #(
    parameter int COUNT_BITS = 32,
    parameter int RTT_BITS   = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lqs_pkg::t_lqs_cmd        i_cmd,
    output lqs_pkg::t_lqs_sts        o_sts,
    input  logic [1:0]               i_func,
    input  logic signed [10:0]       i_rssi_q,
    input  logic signed [8:0]        i_snr_q,
    input  logic [23:0]              i_round_trip_ms,
    output logic [31:0]              o_sent_total,
    output logic [31:0]              o_received_total,
    output logic [13:0]              o_loss_centipct,
    output logic signed [10:0]       o_rssi_lowest,
    output logic signed [10:0]       o_rssi_highest,
    output logic signed [10:0]       o_rssi_mean,
    output logic signed [8:0]        o_snr_lowest,
    output logic signed [8:0]        o_snr_highest,
    output logic signed [8:0]        o_snr_mean,
    output logic [RTT_BITS-1:0]      o_rtt_lowest,
    output logic [RTT_BITS-1:0]      o_rtt_highest,
    output logic [RTT_BITS-1:0]      o_rtt_mean
);
    import lqs_pkg::*;

    localparam int RS_W  = COUNT_BITS + RSSI_W;
    localparam int SS_W  = COUNT_BITS + SNR_W;
    localparam int TS_W  = COUNT_BITS + RTT_BITS;
    // widest dividend: rtt sum or the scaled loss difference
    localparam int NUM_W = COUNT_BITS + ((RTT_BITS > LOSS_W) ? RTT_BITS : LOSS_W);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0]  r_sent, r_recv;
    logic signed [RS_W-1:0] r_rsum;
    logic signed [SS_W-1:0] r_ssum;
    logic [TS_W-1:0]        r_tsum;
    logic signed [RSSI_W-1:0] r_rmin, r_rmax;
    logic signed [SNR_W-1:0]  r_smin, r_smax;
    logic [RTT_BITS-1:0]    r_tmin, r_tmax;
    logic [RTT_BITS-1:0]    w_t;

    assign w_t = RTT_BITS'({8'd0, i_round_trip_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.update && i_func == FUNC_CLEAR)) begin
            r_sent <= '0;
            r_recv <= '0;
            r_rsum <= '0;
            r_ssum <= '0;
            r_tsum <= '0;
            r_rmin <= '0;
            r_rmax <= RSSI_W'(RSSI_FLOOR);
            r_smin <= SNR_W'(SNR_LIMIT);
            r_smax <= SNR_W'(-SNR_LIMIT);
            r_tmin <= '1;
            r_tmax <= '0;
        end else if (i_cmd.update) begin
            if (i_func == FUNC_SENT && r_sent != CMAX) r_sent <= r_sent + 1'b1;
            if (i_func == FUNC_RECV) begin
                if (r_recv != CMAX) begin
                    r_recv <= r_recv + 1'b1;
                    r_rsum <= r_rsum + RS_W'(i_rssi_q);
                    r_ssum <= r_ssum + SS_W'(i_snr_q);
                    r_tsum <= r_tsum + TS_W'(w_t);
                end
                if (i_rssi_q < r_rmin) r_rmin <= i_rssi_q;
                if (i_rssi_q > r_rmax) r_rmax <= i_rssi_q;
                if (i_snr_q < r_smin) r_smin <= i_snr_q;
                if (i_snr_q > r_smax) r_smax <= i_snr_q;
                if (w_t < r_tmin) r_tmin <= w_t;
                if (w_t > r_tmax) r_tmax <= w_t;
            end
        end
    end

    // operand select; signed sums divided by magnitude then sign restored
    logic [NUM_W-1:0]      w_num;
    logic [COUNT_BITS-1:0] w_den;
    logic [RS_W-1:0]       w_rabs;
    logic [SS_W-1:0]       w_sabs;
    logic [COUNT_BITS+13:0] w_loss_num;

    assign w_rabs = r_rsum[RS_W-1] ? RS_W'(-r_rsum) : RS_W'(r_rsum);
    assign w_sabs = r_ssum[SS_W-1] ? SS_W'(-r_ssum) : SS_W'(r_ssum);
    assign w_loss_num = 14'(LOSS_SCALE) * (r_sent - r_recv);

    always_comb begin
        w_den = r_recv;
        unique case (i_cmd.div_sel)
            DIV_LOSS: begin
                w_num = NUM_W'(w_loss_num);
                w_den = r_sent;
            end
            DIV_RSSI: w_num = NUM_W'(w_rabs);
            DIV_SNR:  w_num = NUM_W'(w_sabs);
            DIV_RTT:  w_num = NUM_W'(r_tsum);
            default:  w_num = '0;
        endcase
    end

    logic [NUM_W-1:0] w_quot;
    logic             w_done;

    lqs_div #(.NUM_W(NUM_W), .DEN_W(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot),
        .o_done  (w_done)
    );
    assign o_sts.div_done = w_done;

    logic [13:0]          r_loss;
    logic [RSSI_W-1:0]    r_rmean;
    logic [SNR_W-1:0]     r_smean;
    logic [RTT_BITS-1:0]  r_tmean;
    logic [RSSI_W-1:0]    w_rq;
    logic [SNR_W-1:0]     w_sq;

    assign w_rq = w_quot[RSSI_W-1:0];
    assign w_sq = w_quot[SNR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            unique case (i_cmd.div_sel)
                DIV_LOSS: r_loss  <= w_quot[13:0];
                DIV_RSSI: r_rmean <= r_rsum[RS_W-1] ? RSSI_W'(-w_rq) : w_rq;
                DIV_SNR:  r_smean <= r_ssum[SS_W-1] ? SNR_W'(-w_sq) : w_sq;
                DIV_RTT:  r_tmean <= w_quot[RTT_BITS-1:0];
                default:  r_loss  <= r_loss;
            endcase
        end
    end

    logic w_any, w_lok;
    assign w_any = (r_recv != '0);
    assign w_lok = (r_sent != '0) && (r_recv <= r_sent);

    assign o_sent_total     = 32'(r_sent);
    assign o_received_total = 32'(r_recv);
    assign o_loss_centipct  = w_lok ? r_loss : '0;
    assign o_rssi_lowest    = w_any ? r_rmin : '0;
    assign o_rssi_highest   = w_any ? r_rmax : '0;
    assign o_rssi_mean      = w_any ? r_rmean : '0;
    assign o_snr_lowest     = w_any ? r_smin : '0;
    assign o_snr_highest    = w_any ? r_smax : '0;
    assign o_snr_mean       = w_any ? r_smean : '0;
    assign o_rtt_lowest     = w_any ? r_tmin : '0;
    assign o_rtt_highest    = w_any ? r_tmax : '0;
    assign o_rtt_mean       = w_any ? r_tmean : '0;
endmodule

FILE: hdl/link_quality_statistics.sv
// ----------------------------------------------------------------------------
// link_quality_statistics
// Running link statistics: counts, loss, min, max and mean of each metric.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transaction: func in tuser, the rssi, snr
//   and round trip sample in tdata. m_axis returns one summary per event.
//   Each event updates counters, sums and extremes in its accept cycle, then
//   a single restoring divider computes loss and the three means one after
//   another, one quotient bit per cycle over COUNT_BITS + max(RTT_BITS, 14)
//   bits. The next event is taken the cycle after the summary has been
//   delivered. The summary is held in registers and stays stable while
//   m_axis_tready is low; the block takes no new event until it is
//   delivered. Synchronous reset clears all statistics to their idle
//   values; a clear event does the same and still returns a summary.
// ----------------------------------------------------------------------------
module link_quality_statistics #(
    parameter int COUNT_BITS = 32,
    parameter int RTT_BITS   = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // rssi_q[10:0], snr_q[19:11], round_trip_ms[43:20], zero pad
    input  logic [47:0]   s_axis_tdata,
    // func[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // sent_total, received_total, loss_centipct, rssi_lowest, rssi_highest,
    // rssi_mean, snr_lowest, snr_highest, snr_mean, rtt_lowest, rtt_highest,
    // rtt_mean, zero pad; from bit 0
    output logic [((138 + 3*RTT_BITS + 7)/8)*8-1:0] m_axis_tdata
);
    import lqs_pkg::*;

    localparam int OUT_W = ((138 + 3*RTT_BITS + 7)/8)*8;

    t_lqs_cmd w_cmd;
    t_lqs_sts w_sts;

    logic [31:0] w_sent, w_recv;
    logic [13:0] w_loss;
    logic signed [10:0] w_rlo, w_rhi, w_rmn;
    logic signed [8:0]  w_slo, w_shi, w_smn;
    logic [RTT_BITS-1:0] w_tlo, w_thi, w_tmn;

    lqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lqs_datapath #(.COUNT_BITS(COUNT_BITS), .RTT_BITS(RTT_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_func           (s_axis_tuser),
        .i_rssi_q         (s_axis_tdata[10:0]),
        .i_snr_q          (s_axis_tdata[19:11]),
        .i_round_trip_ms  (s_axis_tdata[43:20]),
        .o_sent_total     (w_sent),
        .o_received_total (w_recv),
        .o_loss_centipct  (w_loss),
        .o_rssi_lowest    (w_rlo),
        .o_rssi_highest   (w_rhi),
        .o_rssi_mean      (w_rmn),
        .o_snr_lowest     (w_slo),
        .o_snr_highest    (w_shi),
        .o_snr_mean       (w_smn),
        .o_rtt_lowest     (w_tlo),
        .o_rtt_highest    (w_thi),
        .o_rtt_mean       (w_tmn)
    );

    assign m_axis_tdata = OUT_W'({w_tmn, w_thi, w_tlo, w_smn, w_shi, w_slo,
                                  w_rmn, w_rhi, w_rlo, w_loss, w_recv, w_sent});

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("event accepted while summary pending");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("summary changed while stalled");
    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[77:64] <= 14'd10000)
        else $error("loss out of range");
`endif
endmodule
